FILE: sv/fsbm_pkg.sv
// shared types and constants for the full-search block matching core
// beat structs, command and state codes, store sizes
// no dependencies
package fsbm_pkg;

  localparam int unsigned MAX_BLOCK  = 16;
  localparam int unsigned MAX_SEARCH = 33;
  localparam int unsigned CUR_DEPTH  = MAX_BLOCK * MAX_BLOCK;
  localparam int unsigned REF_SIDE   = MAX_SEARCH + MAX_BLOCK - 1;
  localparam int unsigned REF_DEPTH  = REF_SIDE * REF_SIDE;

  localparam int unsigned CUR_AW   = $clog2(CUR_DEPTH);
  localparam int unsigned REF_AW   = $clog2(REF_DEPTH);
  localparam int unsigned CUR_FW   = $clog2(CUR_DEPTH + 1);
  localparam int unsigned REF_FW   = $clog2(REF_DEPTH + 1);
  localparam int unsigned BS_W     = 5;
  localparam int unsigned CNT_W    = $clog2(MAX_BLOCK);
  localparam int unsigned POS_W    = 6;
  localparam int unsigned SAD_W    = 16;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [BS_W-1:0] BLOCK_SIZE_RESET = 5'd8;
  localparam logic            REG_BLOCK_SIZE   = 1'b0;

  typedef enum logic [1:0] {
    CMD_LOAD_CUR = 2'd0,
    CMD_LOAD_REF = 2'd1,
    CMD_SEARCH   = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [7:0]        pixel;
    logic [POS_W-1:0]  search_width;
    logic [POS_W-1:0]  search_height;
    logic signed [7:0] offset_x;
    logic signed [7:0] offset_y;
  } in_beat_t;

  typedef struct packed {
    logic [SAD_W-1:0]  min_sad;
    logic [POS_W-1:0]  best_x;
    logic [POS_W-1:0]  best_y;
    logic signed [7:0] mv_x;
    logic signed [7:0] mv_y;
  } out_beat_t;

endpackage

FILE: sv/full_search_block_match_sad_core.sv
// top level of the full-search block matching core with sum of absolute differences
// holds the pixel stores, the search sequencer and the shared difference accumulator
// depends on fsbm_pkg

// Load beats (current or reference pixel) are taken one per cycle while the core is idle.
// A search beat holds the input stalled through the run, drain and done states, plus any wait for the
// previous result to leave the output register: one absolute difference is accumulated per
// cycle, set by the single read port of each pixel store. Each search clears both fill counts.
module full_search_block_match_sad_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  fsbm_pkg::in_beat_t                in_beat_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output fsbm_pkg::out_beat_t               out_beat_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fsbm_pkg::PADDR_W-1:0]      paddr,
  input  logic [fsbm_pkg::PDATA_W-1:0]      pwdata,
  output logic [fsbm_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  localparam int unsigned CUR_AW = fsbm_pkg::CUR_AW;
  localparam int unsigned REF_AW = fsbm_pkg::REF_AW;
  localparam int unsigned CNT_W  = fsbm_pkg::CNT_W;
  localparam int unsigned POS_W  = fsbm_pkg::POS_W;
  localparam int unsigned BS_W   = fsbm_pkg::BS_W;
  localparam int unsigned SAD_W  = fsbm_pkg::SAD_W;

  // config register
  logic [BS_W-1:0] block_size_q;
  logic            cfg_we;
  logic            reg_idx;

  assign reg_idx = paddr[fsbm_pkg::PADDR_W-1];
  assign cfg_we  = psel && penable && pwrite && (reg_idx == fsbm_pkg::REG_BLOCK_SIZE);
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == fsbm_pkg::REG_BLOCK_SIZE) ?
                   fsbm_pkg::PDATA_W'(block_size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= fsbm_pkg::BLOCK_SIZE_RESET;
    end else if (cfg_we) begin
      block_size_q <= pwdata[BS_W-1:0];
    end
  end

  // sequencer state
  fsbm_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0]          c_q, c_d, r_q, r_d, bs_m1_q, bs_m1_d;
  logic [POS_W-1:0]          x_q, x_d, y_q, y_d, sw_m1_q, sw_m1_d, sh_m1_q, sh_m1_d;
  logic [POS_W-1:0]          stride_q, stride_d;
  logic [7:0]                ox_q, ox_d, oy_q, oy_d;
  logic [CUR_AW-1:0]         cur_addr_q, cur_addr_d;
  logic [REF_AW-1:0]         ref_row_q, ref_row_d, cand_q, cand_d, ybase_q, ybase_d;
  logic [fsbm_pkg::CUR_FW-1:0] cur_fill_q;
  logic [fsbm_pkg::REF_FW-1:0] ref_fill_q;

  logic in_acc, cur_we, ref_we, iss_valid, iss_first, iss_last, iss_final, out_load;
  logic [POS_W-1:0] sw_cl, sh_cl;
  logic [BS_W-1:0]  bs_cl;
  logic [REF_AW-1:0] ref_raddr;

  assign in_stall_o = (state_q != fsbm_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    priority if (in_beat_i.search_width == '0) sw_cl = POS_W'(1);
    else if (in_beat_i.search_width > POS_W'(fsbm_pkg::MAX_SEARCH))
      sw_cl = POS_W'(fsbm_pkg::MAX_SEARCH);
    else sw_cl = in_beat_i.search_width;
    priority if (in_beat_i.search_height == '0) sh_cl = POS_W'(1);
    else if (in_beat_i.search_height > POS_W'(fsbm_pkg::MAX_SEARCH))
      sh_cl = POS_W'(fsbm_pkg::MAX_SEARCH);
    else sh_cl = in_beat_i.search_height;
    priority if (block_size_q == '0) bs_cl = BS_W'(1);
    else if (block_size_q > BS_W'(fsbm_pkg::MAX_BLOCK)) bs_cl = BS_W'(fsbm_pkg::MAX_BLOCK);
    else bs_cl = block_size_q;
  end

  assign iss_first = (c_q == '0) && (r_q == '0);
  assign iss_last  = (c_q == bs_m1_q) && (r_q == bs_m1_q);
  assign iss_final = iss_last && (x_q == sw_m1_q) && (y_q == sh_m1_q);
  assign ref_raddr = ref_row_q + REF_AW'(c_q);

  always_comb begin
    state_d    = state_q;
    c_d        = c_q;
    r_d        = r_q;
    x_d        = x_q;
    y_d        = y_q;
    bs_m1_d    = bs_m1_q;
    sw_m1_d    = sw_m1_q;
    sh_m1_d    = sh_m1_q;
    stride_d   = stride_q;
    ox_d       = ox_q;
    oy_d       = oy_q;
    cur_addr_d = cur_addr_q;
    ref_row_d  = ref_row_q;
    cand_d     = cand_q;
    ybase_d    = ybase_q;
    cur_we     = 1'b0;
    ref_we     = 1'b0;
    iss_valid  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      fsbm_pkg::S_IDLE: begin
        if (in_acc) begin
          priority if (in_beat_i.cmd == fsbm_pkg::CMD_LOAD_CUR) begin
            cur_we = (cur_fill_q < fsbm_pkg::CUR_FW'(fsbm_pkg::CUR_DEPTH));
          end else if (in_beat_i.cmd == fsbm_pkg::CMD_LOAD_REF) begin
            ref_we = (ref_fill_q < fsbm_pkg::REF_FW'(fsbm_pkg::REF_DEPTH));
          end else if (in_beat_i.cmd == fsbm_pkg::CMD_SEARCH) begin
            state_d    = fsbm_pkg::S_RUN;
            c_d        = '0;
            r_d        = '0;
            x_d        = '0;
            y_d        = '0;
            bs_m1_d    = CNT_W'(bs_cl - BS_W'(1));
            sw_m1_d    = sw_cl - POS_W'(1);
            sh_m1_d    = sh_cl - POS_W'(1);
            stride_d   = POS_W'(sw_cl + POS_W'(bs_cl) - POS_W'(1));
            ox_d       = in_beat_i.offset_x;
            oy_d       = in_beat_i.offset_y;
            cur_addr_d = '0;
            ref_row_d  = '0;
            cand_d     = '0;
            ybase_d    = '0;
          end else begin
            state_d = fsbm_pkg::S_IDLE;
          end
        end
      end
      fsbm_pkg::S_RUN: begin
        iss_valid  = 1'b1;
        cur_addr_d = cur_addr_q + CUR_AW'(1);
        if (c_q != bs_m1_q) begin
          c_d = c_q + CNT_W'(1);
        end else begin
          c_d = '0;
          if (r_q != bs_m1_q) begin
            r_d       = r_q + CNT_W'(1);
            ref_row_d = ref_row_q + REF_AW'(stride_q);
          end else begin
            r_d        = '0;
            cur_addr_d = '0;
            if (x_q != sw_m1_q) begin
              x_d       = x_q + POS_W'(1);
              cand_d    = cand_q + REF_AW'(1);
              ref_row_d = cand_q + REF_AW'(1);
            end else begin
              x_d = '0;
              if (y_q != sh_m1_q) begin
                y_d       = y_q + POS_W'(1);
                ybase_d   = ybase_q + REF_AW'(stride_q);
                cand_d    = ybase_q + REF_AW'(stride_q);
                ref_row_d = ybase_q + REF_AW'(stride_q);
              end else begin
                state_d = fsbm_pkg::S_DRAIN;
              end
            end
          end
        end
      end
      fsbm_pkg::S_DRAIN: begin
        state_d = fsbm_pkg::S_DONE;
      end
      fsbm_pkg::S_DONE: begin
        if (!out_valid_o || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = fsbm_pkg::S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= fsbm_pkg::S_IDLE;
      cur_fill_q <= '0;
      ref_fill_q <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        cur_fill_q <= '0;
        ref_fill_q <= '0;
      end else begin
        if (cur_we) cur_fill_q <= cur_fill_q + fsbm_pkg::CUR_FW'(1);
        if (ref_we) ref_fill_q <= ref_fill_q + fsbm_pkg::REF_FW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    c_q        <= c_d;
    r_q        <= r_d;
    x_q        <= x_d;
    y_q        <= y_d;
    bs_m1_q    <= bs_m1_d;
    sw_m1_q    <= sw_m1_d;
    sh_m1_q    <= sh_m1_d;
    stride_q   <= stride_d;
    ox_q       <= ox_d;
    oy_q       <= oy_d;
    cur_addr_q <= cur_addr_d;
    ref_row_q  <= ref_row_d;
    cand_q     <= cand_d;
    ybase_q    <= ybase_d;
  end

  // pixel stores
  logic [7:0] cur_mem [fsbm_pkg::CUR_DEPTH];
  logic [7:0] ref_mem [fsbm_pkg::REF_DEPTH];
  logic [7:0] cur_rd_q, ref_rd_q;

  always_ff @(posedge clk_i) begin
    if (cur_we) cur_mem[cur_fill_q[CUR_AW-1:0]] <= in_beat_i.pixel;
    cur_rd_q <= cur_mem[cur_addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (ref_we) ref_mem[ref_fill_q[REF_AW-1:0]] <= in_beat_i.pixel;
    ref_rd_q <= ref_mem[ref_raddr];
  end

  // accumulate stage, aligned with the registered read data
  logic             p1_valid_q, p1_first_q, p1_last_q;
  logic [POS_W-1:0] p1_x_q, p1_y_q;
  logic [SAD_W-1:0] sum_q, sum_d, best_q, best_d;
  logic [POS_W-1:0] bx_q, bx_d, by_q, by_d;
  logic [7:0]       absd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else begin
      p1_valid_q <= iss_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_first_q <= iss_first;
    p1_last_q  <= iss_last;
    p1_x_q     <= x_q;
    p1_y_q     <= y_q;
  end

  assign absd = (cur_rd_q > ref_rd_q) ? (cur_rd_q - ref_rd_q) : (ref_rd_q - cur_rd_q);

  always_comb begin
    sum_d  = sum_q;
    best_d = best_q;
    bx_d   = bx_q;
    by_d   = by_q;
    if (in_acc && (in_beat_i.cmd == fsbm_pkg::CMD_SEARCH)) begin
      best_d = '1;
      bx_d   = '0;
      by_d   = '0;
    end else if (p1_valid_q) begin
      sum_d = (p1_first_q ? '0 : sum_q) + SAD_W'(absd);
      // later position wins a tie
      if (p1_last_q && (sum_d <= best_q)) begin
        best_d = sum_d;
        bx_d   = p1_x_q;
        by_d   = p1_y_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    best_q <= best_d;
    bx_q   <= bx_d;
    by_q   <= by_d;
  end

  // result register
  logic                out_valid_q;
  fsbm_pkg::out_beat_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.min_sad <= best_q;
      out_q.best_x  <= bx_q;
      out_q.best_y  <= by_q;
      out_q.mv_x    <= ox_q + {2'b00, bx_q};
      out_q.mv_y    <= oy_q + {2'b00, by_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

FILE: sv/fsbm_checker.sv
// port-level checker for the full-search block matching core
// bound to full_search_block_match_sad_core, depends on fsbm_pkg
module fsbm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input fsbm_pkg::in_beat_t  in_beat_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input fsbm_pkg::out_beat_t out_beat_o
);

  // stalled result beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_beat_o))
    else $error("result beat changed under stall");

  // a search beat holds off input
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_beat_i.cmd == fsbm_pkg::CMD_SEARCH) |=> in_stall_o)
    else $error("input taken during search");

  // only a search produces a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && in_valid_i && !in_stall_o &&
    (in_beat_i.cmd != fsbm_pkg::CMD_SEARCH) |=> !out_valid_o)
    else $error("result without search");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_beat_o.best_x < 6'(fsbm_pkg::MAX_SEARCH)) &&
                    (out_beat_o.best_y < 6'(fsbm_pkg::MAX_SEARCH)))
    else $error("best position outside window");

endmodule

bind full_search_block_match_sad_core fsbm_checker u_fsbm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_beat_i   (in_beat_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_beat_o  (out_beat_o)
);
